>>> rtl/core/ras_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ras_pkg: shared definitions for the repeating alarm scheduler
// Operation codes, wake codes, time constants and the repeat advance record.
// ----------------------------------------------------------------------------
package ras_pkg;

	localparam int unsigned ALARM_COUNT_DEF = 4;
	localparam int unsigned SECS_PER_DAY    = 86400;
	localparam int unsigned SECS_PER_MIN    = 60;

	// operation codes
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_SET  = 2'd1;
	localparam logic [1:0] OP_STOP = 2'd2;

	// wake choice codes
	localparam logic [1:0] WAKE_NONE   = 2'd0;
	localparam logic [1:0] WAKE_ALARM  = 2'd1;
	localparam logic [1:0] WAKE_MINUTE = 2'd2;

	// result of advancing one fired alarm
	typedef struct packed {
		logic        keep;
		logic [31:0] due;
	} adv_t;

	// seconds in a whole number of days, up to seven
	function automatic logic [19:0] day_secs(input logic [2:0] days);
		return 20'(days) * 20'(SECS_PER_DAY);
	endfunction

endpackage

>>> rtl/core/repeating_alarm_scheduler.sv
`timescale 1ns / 1ps
// Sequence: a tick runs EXEC, FIRE over every slot, SCAN over every slot, then FINAL;
// set, stop and unused codes run EXEC, SCAN and FINAL. done is registered in FINAL.
// A new transaction is not taken while one is in the walk; busy drops in the cycle done is
// shown, so the next start can be taken then. The walk goes slot by slot through one
// compare and advance unit, once to fire (tick only) and once to find the nearest alarm.
// Reset: all slots inactive, minute_wake set to 1. Results are not held off by the receiver.
// ----------------------------------------------------------------------------
// repeating_alarm_scheduler: alarm table with weekday repeat and wake choice
// Applies a set or stop, or for a tick walks the slots one per cycle to fire due
// alarms; then walks them for the nearest future alarm and reports the wake time.
// ----------------------------------------------------------------------------
module repeating_alarm_scheduler
	import ras_pkg::*;
#(
	parameter int unsigned ALARM_COUNT = ALARM_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic [1:0]         slot,
	input  logic [31:0]        now_seconds,
	input  logic [2:0]         now_weekday,
	input  logic [31:0]        due_time,
	input  logic [6:0]         repeat_mask,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	output logic               done,
	output logic [3:0]         fired_mask,
	output logic [1:0]         next_slot,
	output logic signed [32:0] seconds_to_next,
	output logic [1:0]         wake_kind,
	output logic [31:0]        wake_time
);

	localparam int unsigned IDX_W = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ALARM_COUNT - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FIRE,
		ST_SCAN,
		ST_FINAL
	} state_t;

	state_t state_q;

	// alarm table
	logic        slot_active_q [ALARM_COUNT];
	logic [31:0] slot_due_q    [ALARM_COUNT];
	logic [6:0]  slot_repeat_q [ALARM_COUNT];
	logic        minute_wake_q;

	// transaction held for the walk
	logic [1:0]  op_q;
	logic [1:0]  slot_q;
	logic [31:0] now_q;
	logic [2:0]  weekday_q;
	logic [31:0] due_in_q;
	logic [6:0]  rep_in_q;

	// walk state
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] next_q;
	logic             found_q;
	logic [31:0]      best_q;
	logic [3:0]       fired_q;
	logic [5:0]       rem_q;

	// shared slot unit
	logic        cur_active;
	logic [31:0] cur_due;
	logic        due_le_now;
	logic        due_lt_best;
	logic [4:0]  idx_ext;
	adv_t        adv;

	// final stage
	logic        fin_active;
	logic [31:0] fin_due;
	logic [32:0] next_min;
	logic [5:0]  rem60;
	logic        slot_ok;

	assign busy = (state_q != ST_IDLE);

	assign cur_active  = slot_active_q[idx_q];
	assign cur_due     = slot_due_q[idx_q];
	assign due_le_now  = (cur_due <= now_q);
	assign due_lt_best = (cur_due < best_q);
	assign idx_ext     = 5'(idx_q);
	assign slot_ok     = (32'(slot_q) < 32'(ALARM_COUNT));

	ras_advance u_advance (
		.due         (cur_due),
		.repeat_bits (slot_repeat_q[idx_q]),
		.weekday     (weekday_q),
		.adv         (adv)
	);

	// now mod 60: nibble sum of now/4 gives now/4 mod 15
	always_comb begin
		logic [6:0] nsum;
		logic [4:0] fold;
		logic [31:0] quarter;
		nsum    = 7'd0;
		quarter = {2'b00, now_q[31:2]};
		for (int n = 0; n < 8; n++) begin
			nsum = nsum + 7'(quarter[n*4 +: 4]);
		end
		fold = 5'(nsum[6:4]) + 5'(nsum[3:0]);
		if (fold >= 5'd15) begin
			fold = fold - 5'd15;
		end
		rem60 = {fold[3:0], 2'b00} + 6'(now_q[1:0]);
	end

	// nearest alarm, or slot 0 as it stands when none lies ahead
	assign fin_active = found_q ? 1'b1 : slot_active_q[0];
	assign fin_due    = found_q ? best_q : slot_due_q[0];
	assign next_min   = {1'b0, now_q} + 33'(SECS_PER_MIN) - 33'(rem_q);

	// sequencer, table and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			minute_wake_q <= 1'b1;
			done          <= 1'b0;
			idx_q         <= '0;
			for (int s = 0; s < ALARM_COUNT; s++) begin
				slot_active_q[s] <= 1'b0;
			end
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				minute_wake_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q      <= operation;
						slot_q    <= slot;
						now_q     <= now_seconds;
						weekday_q <= now_weekday;
						due_in_q  <= due_time;
						rep_in_q  <= repeat_mask;
						state_q   <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					// apply set or stop, start the walk
					idx_q   <= '0;
					found_q <= 1'b0;
					best_q  <= '0;
					next_q  <= '0;
					fired_q <= '0;
					rem_q   <= rem60;
					if (op_q == OP_SET && slot_ok) begin
						slot_due_q[IDX_W'(slot_q)]    <= due_in_q;
						slot_repeat_q[IDX_W'(slot_q)] <= rep_in_q;
						slot_active_q[IDX_W'(slot_q)] <= 1'b1;
					end else if (op_q == OP_STOP && slot_ok) begin
						slot_active_q[IDX_W'(slot_q)] <= 1'b0;
					end
					state_q <= (op_q == OP_TICK) ? ST_FIRE : ST_SCAN;
				end
				ST_FIRE: begin
					// fire a due slot and move it to its next repeat weekday, or turn it off when it has none
					if (cur_active && due_le_now) begin
						if (idx_ext < 5'd4) begin
							fired_q[idx_ext[1:0]] <= 1'b1;
						end
						slot_due_q[idx_q] <= adv.keep ? adv.due : cur_due;
						if (!adv.keep) begin
							slot_active_q[idx_q] <= 1'b0;
						end
					end
					if (idx_q == IDX_LAST) begin
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SCAN: begin
					// keep the earliest future alarm, lowest slot on a tie
					if (cur_active && !due_le_now && (!found_q || due_lt_best)) begin
						found_q <= 1'b1;
						best_q  <= cur_due;
						next_q  <= idx_q;
					end
					if (idx_q == IDX_LAST) begin
						idx_q   <= '0;
						state_q <= ST_FINAL;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_FINAL: begin
					// choose the wake and present the result
					fired_mask <= fired_q;
					next_slot  <= 2'(next_q);
					if (fin_active) begin
						seconds_to_next <= {1'b0, fin_due} - {1'b0, now_q};
					end else begin
						seconds_to_next <= '1;
					end
					if (fin_active && (!minute_wake_q || ({1'b0, fin_due} < next_min))) begin
						wake_kind <= WAKE_ALARM;
						wake_time <= fin_due;
					end else if (minute_wake_q) begin
						wake_kind <= WAKE_MINUTE;
						wake_time <= next_min[32] ? 32'hFFFF_FFFF : next_min[31:0];
					end else begin
						wake_kind <= WAKE_NONE;
						wake_time <= '0;
					end
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a result only ever appears as the walk ends
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result shown while busy");

	// a taken transaction starts the walk
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("transaction taken without going busy");

	// only a tick can fire alarms
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_q != OP_TICK) |-> (fired_mask == 4'd0))
		else $error("alarm fired on a non-tick operation");

	// no wake means no wake time
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && wake_kind == WAKE_NONE) |-> (wake_time == 32'd0))
		else $error("wake time given with no wake");

	// an alarm wake lies strictly ahead only when it was found ahead
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && wake_kind == WAKE_ALARM && found_q) |-> (seconds_to_next > 33'sd0))
		else $error("future alarm reported at or before now");

endmodule

>>> rtl/core/ras_advance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ras_advance: repeat advance for one fired alarm
// Finds the first later weekday in the repeat mask and moves the due time on
// by that many days, saturating at the top of the 32-bit range.
// ----------------------------------------------------------------------------
module ras_advance
	import ras_pkg::*;
(
	input  logic [31:0] due,
	input  logic [6:0]  repeat_bits,
	input  logic [2:0]  weekday,
	output adv_t        adv
);

	logic        hit;
	logic [2:0]  step;
	logic [3:0]  day;
	logic [32:0] sum;

	// search the six following weekdays for the first repeat bit
	always_comb begin
		hit  = 1'b0;
		step = 3'd0;
		day  = 4'd0;
		for (int i = 1; i < 7; i++) begin
			day = {1'b0, weekday} + 4'(i);
			if (day >= 4'd7) begin
				day = day - 4'd7;
			end
			if (!hit && repeat_bits[day[2:0]]) begin
				hit  = 1'b1;
				step = 3'(i);
			end
		end
	end

	// add the days, clamp on overflow
	assign sum      = {1'b0, due} + 33'(day_secs(step));
	assign adv.keep = hit;
	assign adv.due  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the repeating alarm scheduler
// Drives set, stop, tick and unused commands through the start/busy handshake,
// predicts every result from a local copy of the alarm table and compares each
// done strobe field by field. Covers repeat advance, saturation, both settings
// of minute_wake and long random schedules with ticks that fire alarms.
// ----------------------------------------------------------------------------
module testbench
	import ras_pkg::*;
;

	localparam int ALARMS = ALARM_COUNT_DEF;

	// operation code with no meaning to the block
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [3:0]  fired;
		logic [1:0]  nxt;
		logic [32:0] secs;
		logic [1:0]  kind;
		logic [31:0] wtime;
	} alarm_result_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         operation;
	logic [1:0]         slot;
	logic [31:0]        now_seconds;
	logic [2:0]         now_weekday;
	logic [31:0]        due_time;
	logic [6:0]         repeat_mask;
	logic               cfg_we;
	logic               cfg_wdata;
	logic               done;
	logic [3:0]         fired_mask;
	logic [1:0]         next_slot;
	logic signed [32:0] seconds_to_next;
	logic [1:0]         wake_kind;
	logic [31:0]        wake_time;

	// local copy of the alarm table and the wake register
	logic          alarm_on     [ALARMS];
	logic [31:0]   alarm_due    [ALARMS];
	logic [6:0]    alarm_repeat [ALARMS];
	logic          wake_on_minute;

	alarm_result_t pending_results [$];
	alarm_result_t oldest_result;
	int            error_count;
	int            items_sent;
	int            ticks_fired;
	int            kind_seen [3];
	bit            minute_setting_seen [2];
	bit            steady;

	repeating_alarm_scheduler dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.slot            (slot),
		.now_seconds     (now_seconds),
		.now_weekday     (now_weekday),
		.due_time        (due_time),
		.repeat_mask     (repeat_mask),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.done            (done),
		.fired_mask      (fired_mask),
		.next_slot       (next_slot),
		.seconds_to_next (seconds_to_next),
		.wake_kind       (wake_kind),
		.wake_time       (wake_time)
	);

	// free-running clock
	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		error_count++;
		if (error_count <= 100)
			$display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
	endtask

	// apply one command to the local table and work out the result it gives
	function automatic alarm_result_t predict_schedule(input logic [1:0] op,
			input logic [1:0] sl, input logic [31:0] now, input logic [2:0] wday,
			input logic [31:0] due, input logic [6:0] rep);
		alarm_result_t r;
		logic [63:0]   later;
		logic [63:0]   boundary;
		logic [31:0]   best;
		int            s;
		int            d;
		int            day;
		bit            moved;
		bit            found;
		r = '0;
		case (op)
			OP_TICK: begin
				for (s = 0; s < ALARMS; s++) begin
					if (alarm_on[s] && alarm_due[s] <= now) begin
						r.fired[s] = 1'b1;
						moved = 1'b0;
						// advance to the first repeat day, saturating at the top
						for (d = 1; d < 7 && !moved; d++) begin
							day = (int'(wday) + d) % 7;
							if (alarm_repeat[s][day]) begin
								later = 64'(alarm_due[s]) + 64'(d) * 64'(SECS_PER_DAY);
								alarm_due[s] = (later > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
									: later[31:0];
								moved = 1'b1;
							end
						end
						if (!moved)
							alarm_on[s] = 1'b0;
					end
				end
			end
			OP_SET: begin
				alarm_due[sl]    = due;
				alarm_repeat[sl] = rep;
				alarm_on[sl]     = 1'b1;
			end
			OP_STOP: begin
				alarm_on[sl] = 1'b0;
			end
			default: ;
		endcase

		// nearest future alarm, lowest slot on a tie
		found = 1'b0;
		best  = '0;
		for (s = 0; s < ALARMS; s++) begin
			if (alarm_on[s] && alarm_due[s] > now && (!found || alarm_due[s] < best)) begin
				found = 1'b1;
				best  = alarm_due[s];
				r.nxt = 2'(s);
			end
		end
		r.secs = alarm_on[r.nxt] ? ({1'b0, alarm_due[r.nxt]} - {1'b0, now}) : '1;

		boundary = 64'(now) + 64'(SECS_PER_MIN);
		boundary = boundary - (boundary % 64'(SECS_PER_MIN));
		if (alarm_on[r.nxt] && (!wake_on_minute || 64'(alarm_due[r.nxt]) < boundary)) begin
			r.kind  = WAKE_ALARM;
			r.wtime = alarm_due[r.nxt];
		end else if (wake_on_minute) begin
			r.kind  = WAKE_MINUTE;
			r.wtime = (boundary > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : boundary[31:0];
		end else begin
			r.kind  = WAKE_NONE;
			r.wtime = '0;
		end
		return r;
	endfunction

	function automatic bit take_break();
		return !steady && ($urandom_range(0, 99) < 11);
	endfunction

	// send one command and queue its expected result once busy drops again
	task automatic send_item(input logic [1:0] op, input logic [1:0] sl,
			input logic [31:0] now, input logic [2:0] wday, input logic [31:0] due,
			input logic [6:0] rep);
		alarm_result_t r;
		if (take_break()) begin
			start <= 1'b0;
			@(posedge clk);
			while (take_break())
				@(posedge clk);
		end
		operation   <= op;
		slot        <= sl;
		now_seconds <= now;
		now_weekday <= wday;
		due_time    <= due;
		repeat_mask <= rep;
		start       <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		r = predict_schedule(op, sl, now, wday, due, rep);
		pending_results.push_back(r);
		items_sent++;
		if (r.fired != 0)
			ticks_fired++;
		kind_seen[r.kind]++;
	endtask

	// hold off until every result is in and the block has gone quiet
	task automatic settle_block();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_minute_wake(input bit value);
		settle_block();
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		wake_on_minute = value;
		minute_setting_seen[value] = 1'b1;
	endtask

	// compare every transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 64'(fired_mask), 0);
			end else begin
				oldest_result = pending_results.pop_front();
				if (fired_mask !== oldest_result.fired)
					report_mismatch("fired_mask", 64'(fired_mask), 64'(oldest_result.fired));
				if (next_slot !== oldest_result.nxt)
					report_mismatch("next_slot", 64'(next_slot), 64'(oldest_result.nxt));
				if (seconds_to_next !== oldest_result.secs)
					report_mismatch("seconds_to_next", 64'(seconds_to_next),
						64'(oldest_result.secs));
				if (wake_kind !== oldest_result.kind)
					report_mismatch("wake_kind", 64'(wake_kind), 64'(oldest_result.kind));
				if (wake_time !== oldest_result.wtime)
					report_mismatch("wake_time", 64'(wake_time), 64'(oldest_result.wtime));
			end
		end
	end

	// every command kind, ties, past and equal due times, odd weekdays
	task automatic test_basic_ops();
		send_item(OP_TICK, 2'd0, 32'd0, 3'd1, 32'd0, 7'd0);
		send_item(OP_SET, 2'd0, 32'd100, 3'd0, 32'd1000, 7'h00);
		send_item(OP_SET, 2'd1, 32'd100, 3'd1, 32'd1000, 7'h7F);
		send_item(OP_SET, 2'd2, 32'd100, 3'd2, 32'd130, 7'h01);
		send_item(OP_SET, 2'd3, 32'hFFFF_FFF0, 3'd3, 32'hFFFF_FFFF, 7'h40);
		send_item(OP_SPARE, 2'd3, 32'd200, 3'd4, 32'hFFFF_FFFF, 7'h7F);
		send_item(OP_TICK, 2'd0, 32'd1000, 3'd7, 32'd0, 7'd0);
		send_item(OP_STOP, 2'd1, 32'd1000, 3'd7, 32'd0, 7'd0);
		send_item(OP_STOP, 2'd3, 32'd1000, 3'd7, 32'd0, 7'd0);
		send_item(OP_SET, 2'd0, 32'd1000, 3'd5, 32'd500, 7'h00);
		send_item(OP_TICK, 2'd0, 32'd500, 3'd6, 32'd0, 7'd0);
		send_item(OP_SET, 2'd0, 32'd2000, 3'd6, 32'd2000, 7'h00);
	endtask

	// due time and minute boundary at the top of the range
	task automatic test_saturation();
		send_item(OP_SET, 2'd1, 32'hFFFF_FFF0, 3'd1, 32'hFFFF_0000, 7'h7F);
		send_item(OP_TICK, 2'd0, 32'hFFFF_FFFF, 3'd1, 32'd0, 7'd0);
		send_item(OP_TICK, 2'd0, 32'hFFFF_FFFF, 3'd2, 32'd0, 7'd0);
		send_item(OP_STOP, 2'd1, 32'hFFFF_FFC4, 3'd2, 32'd0, 7'd0);
	endtask

	// wake choice with minute wake off and back on
	task automatic test_minute_wake();
		set_minute_wake(1'b0);
		send_item(OP_SET, 2'd2, 32'd100, 3'd1, 32'd10000, 7'h22);
		send_item(OP_STOP, 2'd2, 32'd100, 3'd1, 32'd0, 7'd0);
		send_item(OP_SET, 2'd2, 32'd100, 3'd1, 32'd150, 7'h04);
		set_minute_wake(1'b1);
		send_item(OP_TICK, 2'd0, 32'd100, 3'd1, 32'd0, 7'd0);
		send_item(OP_SET, 2'd3, 32'd100, 3'd1, 32'd1000000, 7'h10);
		send_item(OP_TICK, 2'd0, 32'd200, 3'd2, 32'd0, 7'd0);
	endtask

	// running wall clock: alarms set ahead of it and some behind it, ticks that walk past them, and noise
	task automatic test_random_schedule();
		longint unsigned wall;
		longint unsigned when;
		int              phase;
		int              n;
		int              pick;
		int              wk_off;
		logic [2:0]      wday;
		wall   = $urandom_range(0, 32'h7FFF_FFFF);
		wk_off = $urandom_range(0, 6);
		for (phase = 0; phase < 6; phase++) begin
			set_minute_wake((phase < 2) ? phase[0] : 1'($urandom_range(0, 1)));
			steady = (phase == 2);
			if (phase == 4)
				wall = 64'hFFFF_0000 - $urandom_range(0, 200000);
			for (n = 0; n < 75; n++) begin
				pick = $urandom_range(0, 99);
				wday = 3'(1 + ((wall / SECS_PER_DAY + wk_off) % 7));
				if ($urandom_range(0, 19) == 0)
					wday = 3'd0;
				if (pick < 15) begin
					send_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom,
						3'($urandom_range(0, 7)), $urandom, 7'($urandom_range(0, 127)));
				end else if (pick < 40) begin
					when = wall + $urandom_range(0, 3 * SECS_PER_DAY);
					if ($urandom_range(0, 4) == 0 && wall >= 5000)
						when = wall - $urandom_range(0, 5000);
					if (when > 64'hFFFF_FFFF)
						when = 64'hFFFF_FFFF;
					send_item(OP_SET, 2'($urandom_range(0, 3)), 32'(wall), wday, 32'(when),
						7'($urandom_range(0, 127)));
				end else if (pick < 47) begin
					send_item(OP_STOP, 2'($urandom_range(0, 3)), 32'(wall), wday, $urandom,
						7'($urandom_range(0, 127)));
				end else begin
					send_item(OP_TICK, 2'($urandom_range(0, 3)), 32'(wall), wday, $urandom,
						7'($urandom_range(0, 127)));
					wall += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200000)
						: $urandom_range(0, 30000);
					if (wall > 64'hFFFF_FFFF)
						wall = $urandom_range(0, 32'h7FFF_FFFF);
				end
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		start       = 1'b0;
		operation   = OP_TICK;
		slot        = '0;
		now_seconds = '0;
		now_weekday = 3'd1;
		due_time    = '0;
		repeat_mask = '0;
		cfg_we      = 1'b0;
		cfg_wdata   = 1'b0;
		error_count = 0;
		items_sent  = 0;
		ticks_fired = 0;
		steady      = 1'b0;
		for (int s = 0; s < ALARMS; s++) begin
			alarm_on[s]     = 1'b0;
			alarm_due[s]    = '0;
			alarm_repeat[s] = '0;
		end
		wake_on_minute = 1'b1;
		minute_setting_seen[1] = 1'b1;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_saturation();
		test_minute_wake();
		test_random_schedule();
		settle_block();

		$display("covered %0d transactions, %0d with alarms firing, minute_wake 0 and 1: %0b%0b",
			items_sent, ticks_fired, minute_setting_seen[0], minute_setting_seen[1]);
		$display("wake choices seen: none %0d, alarm %0d, minute %0d",
			kind_seen[0], kind_seen[1], kind_seen[2]);
		if (error_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// stop a hung run
	initial begin
		#5_000_000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/ras_pkg.sv
rtl/core/ras_advance.sv
rtl/core/repeating_alarm_scheduler.sv
tb/sv/testbench.sv
